@@ design/ntbs_pkg.sv @@
// ----------------------------------------------------------------------------
// ntbs_pkg
// Shared types, constants and base code helpers for the two-bit base store.
// ----------------------------------------------------------------------------
`default_nettype none

package ntbs_pkg;

  localparam int unsigned MAX_BASES = 65536;
  localparam int unsigned MAX_SPAN  = 64;

  localparam int unsigned POS_W   = $clog2(MAX_BASES);
  localparam int unsigned CNT_W   = POS_W + 1;
  localparam int unsigned ADDR_W  = POS_W - 2;
  localparam int unsigned DEPTH   = MAX_BASES / 4;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC = 8'h43;
  localparam logic [CHAR_W-1:0] CH_UG = 8'h47;
  localparam logic [CHAR_W-1:0] CH_UT = 8'h54;
  localparam logic [CHAR_W-1:0] CH_LC = 8'h63;
  localparam logic [CHAR_W-1:0] CH_LG = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LT = 8'h74;
  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND  = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_READ_FW = 2'd2,
    MODE_READ_RC = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_SPAN = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic             append;
    logic [1:0]       code;
    logic             clear;
    logic             rd_en;
    logic [POS_W-1:0] rd_pos;
  } store_cmd_t;

  typedef struct packed {
    logic              load;
    logic [CHAR_W-1:0] chr;
    logic              last;
    status_e           status;
  } out_word_t;

  function automatic logic [1:0] code_of_char(input logic [CHAR_W-1:0] ch);
    logic [1:0] code;
    case (ch)
      CH_UC, CH_LC: code = 2'd1;
      CH_UG, CH_LG: code = 2'd2;
      CH_UT, CH_LT: code = 2'd3;
      default:      code = 2'd0;
    endcase
    return code;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of_code(input logic [1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      2'd0:    ch = CH_UA;
      2'd1:    ch = CH_UC;
      2'd2:    ch = CH_UG;
      default: ch = CH_UT;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ design/ntbs_store.sv @@
// ----------------------------------------------------------------------------
// ntbs_store
// Packed base memory, base count and partial group; one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ntbs_store (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ntbs_pkg::store_cmd_t         cmd_i,
  output logic [ntbs_pkg::CNT_W-1:0]   count_o,
  output logic [1:0]                   code_o
);
  import ntbs_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CHAR_W-1:0] part_q, part_d;
  logic [CHAR_W-1:0] rdata_q;
  logic              sel_part_q;
  logic [1:0]        lane_q;

  logic [CHAR_W-1:0] merged;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] sel_byte;

  always_comb begin
    merged  = part_q | (CHAR_W'(cmd_i.code) << {~count_q[1:0], 1'b0});
    wr_addr = count_q[POS_W-1:2];
    rd_addr = cmd_i.rd_pos[POS_W-1:2];
    wr_en   = 1'b0;
    count_d = count_q;
    part_d  = part_q;
    if (cmd_i.clear) begin
      count_d = '0;
      part_d  = '0;
    end else if (cmd_i.append) begin
      count_d = count_q + CNT_W'(1);
      if (count_q[1:0] == 2'd3) begin
        wr_en  = 1'b1;
        part_d = '0;
      end else begin
        part_d = merged;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      part_q  <= '0;
    end else begin
      count_q <= count_d;
      part_q  <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= merged;
    end
    if (cmd_i.rd_en) begin
      rdata_q    <= mem[rd_addr];
      sel_part_q <= ({1'b0, rd_addr} == count_q[CNT_W-1:2]);
      lane_q     <= cmd_i.rd_pos[1:0];
    end
  end

  always_comb begin
    sel_byte = sel_part_q ? part_q : rdata_q;
    code_o   = sel_byte[{~lane_q, 1'b0} +: 2];
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

@@ design/ntbs_seq.sv @@
// ----------------------------------------------------------------------------
// ntbs_seq
// Sequencer: decodes items, checks spans, steps the read position per base.
// ----------------------------------------------------------------------------
`default_nettype none

module ntbs_seq (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [ntbs_pkg::MODE_W-1:0]    mode_i,
  input  wire  [ntbs_pkg::CHAR_W-1:0]    base_char_i,
  input  wire  [ntbs_pkg::START_W-1:0]   start_pos_i,
  input  wire  [ntbs_pkg::LEN_W-1:0]     span_length_i,
  input  wire                            out_free_i,
  output ntbs_pkg::out_word_t            out_word_o,
  output ntbs_pkg::store_cmd_t           cmd_o,
  input  wire  [ntbs_pkg::CNT_W-1:0]     count_i,
  input  wire  [1:0]                     code_i
);
  import ntbs_pkg::*;

  seq_state_e       state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic             rev_q, rev_d;

  logic             accept;
  logic             span_bad;
  logic [CNT_W-1:0] span_end;
  logic [POS_W-1:0] pos_step;
  logic [1:0]       code_eff;
  mode_e            mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      left_q  <= '0;
      rev_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      rev_q   <= rev_d;
    end
  end

  always_comb begin
    mode     = mode_e'(mode_i);
    span_end = CNT_W'(start_pos_i) + CNT_W'(span_length_i);
    span_bad = (span_length_i == '0) || (span_length_i > LEN_W'(MAX_SPAN))
             || (span_end > count_i);
    pos_step = rev_q ? (pos_q - POS_W'(1)) : (pos_q + POS_W'(1));
    code_eff = rev_q ? ~code_i : code_i;

    in_ready_o = (state_q == ST_IDLE) && out_free_i;
    accept     = in_valid_i && in_ready_o;

    state_d = state_q;
    pos_d   = pos_q;
    left_d  = left_q;
    rev_d   = rev_q;

    cmd_o        = '0;
    cmd_o.code   = code_of_char(base_char_i);
    cmd_o.rd_pos = pos_q;

    out_word_o        = '0;
    out_word_o.status = STAT_OK;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_APPEND: begin
              if (count_i >= CNT_W'(MAX_BASES)) begin
                out_word_o.load   = 1'b1;
                out_word_o.chr    = CH_NONE;
                out_word_o.last   = 1'b1;
                out_word_o.status = STAT_FULL;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
              if (span_bad) begin
                out_word_o.load   = 1'b1;
                out_word_o.chr    = CH_NONE;
                out_word_o.last   = 1'b1;
                out_word_o.status = STAT_SPAN;
              end else begin
                rev_d   = (mode == MODE_READ_RC);
                left_d  = span_length_i;
                pos_d   = (mode == MODE_READ_RC)
                        ? POS_W'(count_i - CNT_W'(1) - CNT_W'(start_pos_i))
                        : POS_W'(start_pos_i);
                state_d = ST_FETCH;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          out_word_o.load = 1'b1;
          out_word_o.chr  = char_of_code(code_eff);
          out_word_o.last = (left_q == LEN_W'(1));
          left_d          = left_q - LEN_W'(1);
          pos_d           = pos_step;
          if (left_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_pos = pos_step;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/nucleotide_two_bit_store.sv @@
// ----------------------------------------------------------------------------
// nucleotide_two_bit_store
// DNA base store, four 2-bit bases per byte, with forward and
// reverse-complement reads.
//
// Input channel (in_valid_i/in_ready_o) takes one word per item: append a
// base, clear, read forward or read reverse complement. Output channel
// (out_valid_o/out_ready_i) gives one word per emitted base, last_flag_o
// on the final one, or a single status word on an error.
// Append and clear produce no word (append on a full store gives one
// status word). A read first issues a memory fetch from the fetch state,
// then emits one base per cycle, unless the receiver stalls, through the
// one-read-port byte memory; its first base passes the fetch state, the
// registered memory read and the output register before it is presented.
// Input is accepted only while the sequencer is idle and the output
// register is free or being drained. A stalled receiver holds the output
// word and pauses the read sequencer. Reset empties the store; memory
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nucleotide_two_bit_store (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [ntbs_pkg::MODE_W-1:0]   mode_i,
  input  wire  [ntbs_pkg::CHAR_W-1:0]   base_char_i,
  input  wire  [ntbs_pkg::START_W-1:0]  start_pos_i,
  input  wire  [ntbs_pkg::LEN_W-1:0]    span_length_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [ntbs_pkg::CHAR_W-1:0]   out_char_o,
  output logic                          last_flag_o,
  output logic [ntbs_pkg::STAT_W-1:0]   status_o
);
  import ntbs_pkg::*;

  store_cmd_t        cmd;
  out_word_t         out_word;
  logic [CNT_W-1:0]  count;
  logic [1:0]        code;
  logic              out_free;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              last_q;
  logic [STAT_W-1:0] status_q;

  assign out_free = !out_valid_q || out_ready_i;

  ntbs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .base_char_i   (base_char_i),
    .start_pos_i   (start_pos_i),
    .span_length_i (span_length_i),
    .out_free_i    (out_free),
    .out_word_o    (out_word),
    .cmd_o         (cmd),
    .count_i       (count),
    .code_i        (code)
  );

  ntbs_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .count_o (count),
    .code_o  (code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= out_word.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && out_word.load) begin
      out_char_q <= out_word.chr;
      last_q     <= out_word.last;
      status_q   <= out_word.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_flag_o = last_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire
